/* hw/rtl/bfcd_pkg.sv */
// Package with the types and constants shared by the frame change detector modules.
`timescale 1ns / 1ps

package bfcd_pkg;

  // Configuration port geometry: two 32-bit registers at byte addresses 0 and 4.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Register indexes, taken from paddr[2].
  typedef enum logic [0:0] {
    REG_GRAY_THRESHOLD = 1'b0,
    REG_DIFF_LIMIT     = 1'b1
  } reg_index_t;

  // Reset values of the registers.
  localparam logic [7:0]  GRAY_THRESHOLD_RST = 8'd50;
  localparam logic [31:0] DIFF_LIMIT_RST     = 32'd0;

  // Luma coefficients in Q0.16.
  localparam logic [15:0] LUMA_COEF_R = 16'd19588;
  localparam logic [15:0] LUMA_COEF_G = 16'd38470;
  localparam logic [15:0] LUMA_COEF_B = 16'd7471;

  // Binary pixel levels and sum saturation value.
  localparam logic [7:0]  PIX_ON  = 8'hFF;
  localparam logic [7:0]  PIX_OFF = 8'h00;
  localparam logic [31:0] SUM_MAX = 32'hFFFF_FFFF;

  // One binarized pixel on its way to the accumulator.
  typedef struct packed {
    logic [7:0] binary;
    logic [7:0] diff;
    logic       last;
  } pix_stage_t;

endpackage

/* hw/rtl/bfcd_regs.sv */
// APB-style configuration registers for the frame change detector.
`timescale 1ns / 1ps

module bfcd_regs
  import bfcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [7:0]        gray_threshold,
  output logic [31:0]       diff_limit
);

  reg_index_t reg_sel;
  logic       wr_en;

  assign reg_sel = reg_index_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      gray_threshold <= GRAY_THRESHOLD_RST;
      diff_limit     <= DIFF_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_GRAY_THRESHOLD: gray_threshold <= pwdata[7:0];
        REG_DIFF_LIMIT:     diff_limit     <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Read data follows the address.
  always_comb begin
    unique case (reg_sel)
      REG_GRAY_THRESHOLD: prdata = {24'd0, gray_threshold};
      REG_DIFF_LIMIT:     prdata = diff_limit;
      default:            prdata = '0;
    endcase
  end

endmodule

/* hw/rtl/bfcd_luma.sv */
// Input register, luma conversion, binarization and reference difference.
`timescale 1ns / 1ps

module bfcd_luma
  import bfcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] ref_pixel,
  input  logic       last_pixel,
  input  logic [7:0] gray_threshold,
  output logic       stage_valid,
  output pix_stage_t stage
);

  logic        in_reg_valid;
  logic [7:0]  red_q;
  logic [7:0]  green_q;
  logic [7:0]  blue_q;
  logic [7:0]  ref_q;
  logic        last_q;
  logic [23:0] luma_acc;
  logic [7:0]  luma;
  pix_stage_t  stage_next;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (en) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      red_q   <= red;
      green_q <= green;
      blue_q  <= blue;
      ref_q   <= ref_pixel;
      last_q  <= last_pixel;
    end
  end

  // Luma is the weighted sum truncated to its integer part; it never exceeds 254.
  always_comb begin
    luma_acc = 24'(LUMA_COEF_R) * 24'(red_q) + 24'(LUMA_COEF_G) * 24'(green_q)
             + 24'(LUMA_COEF_B) * 24'(blue_q);
    luma     = luma_acc[23:16];
    stage_next.binary = (luma > gray_threshold) ? PIX_ON : PIX_OFF;
    stage_next.last   = last_q;
    // The binary value is either all ones or zero, so the absolute difference is simple.
    if (stage_next.binary == PIX_ON) begin
      stage_next.diff = PIX_ON - ref_q;
    end else begin
      stage_next.diff = ref_q;
    end
  end

  // Binarized pixel register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (en) begin
      stage_valid <= in_reg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_reg_valid) begin
      stage <= stage_next;
    end
  end

endmodule

/* hw/rtl/bfcd_accum.sv */
// Frame difference accumulator with freeze, detection and the result register.
`timescale 1ns / 1ps

module bfcd_accum
  import bfcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        stage_valid,
  input  pix_stage_t  stage,
  input  logic [31:0] diff_limit,
  output logic        result_valid,
  output logic [7:0]  binary_pixel,
  output logic        frame_done,
  output logic [31:0] frame_total,
  output logic        detected
);

  logic [31:0] running_sum;
  logic        exceeded;
  logic [32:0] sum_wide;
  logic [31:0] sum_sat;
  logic [31:0] sum_next;
  logic        over_limit;
  logic        take;

  assign take = en && stage_valid;

  // Saturating add, skipped once the sum has gone over the limit.
  always_comb begin
    sum_wide   = {1'b0, running_sum} + {25'd0, stage.diff};
    sum_sat    = sum_wide[32] ? SUM_MAX : sum_wide[31:0];
    sum_next   = exceeded ? running_sum : sum_sat;
    over_limit = sum_next > diff_limit;
  end

  // Frame state, cleared after the last pixel of a frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      exceeded    <= 1'b0;
    end else if (take) begin
      if (stage.last) begin
        running_sum <= '0;
        exceeded    <= 1'b0;
      end else begin
        running_sum <= sum_next;
        exceeded    <= exceeded || over_limit;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      binary_pixel <= stage.binary;
      frame_done   <= stage.last;
      frame_total  <= stage.last ? sum_next : 32'd0;
      detected     <= stage.last && over_limit;
    end
  end

  // The frame state is clear after a closing pixel.
  assert property (@(posedge clk) disable iff (rst)
    take && stage.last |=> running_sum == 32'd0 && !exceeded)
    else $error("frame state not cleared after last pixel");

  // A frozen sum does not move within the frame.
  assert property (@(posedge clk) disable iff (rst)
    take && exceeded && !stage.last |=> running_sum == $past(running_sum))
    else $error("frozen sum changed");

  // Sum and flag are zero on words that do not close a frame.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !frame_done |-> frame_total == 32'd0 && !detected)
    else $error("frame totals on a word inside the frame");

  // The binary pixel is one of its two levels.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> binary_pixel == PIX_ON || binary_pixel == PIX_OFF)
    else $error("binary pixel out of range");

endmodule

/* hw/rtl/binary_frame_change_detector_core.sv */
// Top level of the binary frame change detector.
`timescale 1ns / 1ps
//
// Channel   Handshake                    Word
// pixel     pixel_valid / pixel_stall    red, green, blue, ref_pixel, last_pixel
// result    result_valid / result_stall  binary_pixel, frame_done, frame_total, detected
// config    psel, penable, pwrite        paddr, pwdata, prdata, pready
//
// An accepted word passes the input register, the luma and binarize register, then the
// accumulator and result register, before its result is presented on the result channel.
// A new word is accepted every cycle unless the pipeline holds; the accumulator sets this rate.
// The whole pipeline holds while the result register is full and stalled.
// Reset sets gray_threshold to 50, diff_limit to 0 and clears the frame sum.

module binary_frame_change_detector_core
  import bfcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic [7:0]        ref_pixel,
  input  logic              last_pixel,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [7:0]        binary_pixel,
  output logic              frame_done,
  output logic [31:0]       frame_total,
  output logic              detected,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic        en;
  logic [7:0]  gray_threshold;
  logic [31:0] diff_limit;
  logic        stage_valid;
  pix_stage_t  stage;

  // The pipeline moves whenever the result register can take a word.
  assign en          = !result_valid || !result_stall;
  assign pixel_stall = !en;

  bfcd_regs u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .gray_threshold (gray_threshold),
    .diff_limit     (diff_limit)
  );

  bfcd_luma u_luma (
    .clk            (clk),
    .rst            (rst),
    .en             (en),
    .in_valid       (pixel_valid),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .ref_pixel      (ref_pixel),
    .last_pixel     (last_pixel),
    .gray_threshold (gray_threshold),
    .stage_valid    (stage_valid),
    .stage          (stage)
  );

  bfcd_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .stage_valid  (stage_valid),
    .stage        (stage),
    .diff_limit   (diff_limit),
    .result_valid (result_valid),
    .binary_pixel (binary_pixel),
    .frame_done   (frame_done),
    .frame_total  (frame_total),
    .detected     (detected)
  );

endmodule
